// ----- src/dbt_pkg.sv -----
// ----------------------------------------------------------------------------
// dbt_pkg
// Shared constants and controller/datapath interface types for the depth test.
// ----------------------------------------------------------------------------
package dbt_pkg;

  localparam int CoordBits   = 8;
  localparam int WidthBits   = 9;
  localparam int DepthBits   = 24;
  localparam int MaxWidth    = 256;
  localparam int MaxHeight   = 256;
  localparam int StoreSize   = MaxWidth * MaxHeight;
  localparam int AddrBits    = $clog2(StoreSize);
  localparam int ProdBits    = CoordBits + WidthBits;
  localparam int SumBits     = ProdBits + 1;
  localparam int InDataBits  = 2 * CoordBits + DepthBits;
  localparam int OutDataBits = 8;

  typedef struct packed {
    logic clear_wr;
    logic load_in;
    logic rd_en;
    logic finish;
  } dbt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dbt_sts_t;

endpackage

// ----- src/depth_buffer_test.sv -----
// ----------------------------------------------------------------------------
// depth_buffer_test
// Z-buffer depth test, less-or-equal passes, with on-chip depth store.
// ----------------------------------------------------------------------------
// Sequence: a fragment is registered on acceptance; the address state forms the
// address and reads the store; the read state, once the output is free, compares,
// writes the store on a pass and registers the result. No new fragment is taken
// until then. Reset: store cleared to farthest depth by a pass, one entry per
// cycle; no input transaction is taken meanwhile. Width register resets to 256.
module depth_buffer_test (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // pixel_x[7:0], pixel_y[15:8], frag_depth[39:16]
  input  logic        s_axis_tuser_i,  // frag_alive
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // pass[0], zero fill[7:1]
  output logic        m_axis_tuser_o,  // out_of_range
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i       // screen_width
);
  import dbt_pkg::*;

  dbt_cmd_t             cmd;
  dbt_sts_t             sts;
  logic [WidthBits-1:0] width_q;
  logic                 pass;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthBits'(MaxWidth);
    end else if (cfg_valid_i) begin
      width_q <= cfg_data_i;
    end
  end

  dbt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dbt_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .width_i       (width_q),
    .pixel_x_i     (s_axis_tdata_i[CoordBits-1:0]),
    .pixel_y_i     (s_axis_tdata_i[2*CoordBits-1:CoordBits]),
    .frag_depth_i  (s_axis_tdata_i[InDataBits-1:2*CoordBits]),
    .frag_alive_i  (s_axis_tuser_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .pass_o        (pass),
    .out_of_range_o(m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(OutDataBits-1){1'b0}}, pass};

endmodule

// ----- src/dbt_ram.sv -----
// ----------------------------------------------------------------------------
// dbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dbt_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/dbt_ctrl.sv -----
// ----------------------------------------------------------------------------
// dbt_ctrl
// Sequencer: store clearing pass, then accept / address / read-modify-write.
// ----------------------------------------------------------------------------
module dbt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dbt_pkg::dbt_sts_t sts_i,
  output dbt_pkg::dbt_cmd_t cmd_o
);
  import dbt_pkg::*;

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StAddr  = 2'd2;
  localparam logic [1:0] StRead  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StClear: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StAddr;
        end
      end
      StAddr: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StRead;
      end
      StRead: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StClear;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/dbt_dpath.sv -----
// ----------------------------------------------------------------------------
// dbt_dpath
// Fragment registers, address and range check, depth store, compare and
// result register.
// ----------------------------------------------------------------------------
module dbt_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dbt_pkg::dbt_cmd_t            cmd_i,
  output dbt_pkg::dbt_sts_t            sts_o,
  input  logic [dbt_pkg::WidthBits-1:0] width_i,
  input  logic [dbt_pkg::CoordBits-1:0] pixel_x_i,
  input  logic [dbt_pkg::CoordBits-1:0] pixel_y_i,
  input  logic [dbt_pkg::DepthBits-1:0] frag_depth_i,
  input  logic                         frag_alive_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         pass_o,
  output logic                         out_of_range_o
);
  import dbt_pkg::*;

  logic [CoordBits-1:0] x_q, y_q;
  logic [DepthBits-1:0] depth_q;
  logic                 alive_q;
  logic [AddrBits-1:0]  addr_q;
  logic                 oor_q;
  logic [AddrBits-1:0]  clr_cnt_q;
  logic                 out_valid_q, pass_q, oor_out_q;

  logic [ProdBits-1:0]  prod;
  logic [SumBits-1:0]   addr_full;
  logic                 oor_d;
  logic [DepthBits-1:0] rd_depth;
  logic                 hit;
  logic                 ram_we;
  logic [AddrBits-1:0]  ram_waddr;
  logic [DepthBits-1:0] ram_wdata;

  assign prod      = ProdBits'(y_q) * ProdBits'(width_i);
  assign addr_full = SumBits'(prod) + SumBits'(x_q);
  assign oor_d     = ({1'b0, x_q} >= width_i) || (addr_full >= SumBits'(StoreSize));

  assign hit       = alive_q && !oor_q && (rd_depth >= depth_q);
  assign ram_we    = cmd_i.clear_wr || (cmd_i.finish && hit);
  assign ram_waddr = cmd_i.clear_wr ? clr_cnt_q : addr_q;
  assign ram_wdata = cmd_i.clear_wr ? {DepthBits{1'b1}} : depth_q;

  dbt_ram #(
    .Width(DepthBits),
    .Depth(StoreSize)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(addr_full[AddrBits-1:0]),
    .rdata_o(rd_depth)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q     <= pixel_x_i;
      y_q     <= pixel_y_i;
      depth_q <= frag_depth_i;
      alive_q <= frag_alive_i;
    end
    if (cmd_i.rd_en) begin
      addr_q <= addr_full[AddrBits-1:0];
      oor_q  <= oor_d;
    end
    if (cmd_i.finish) begin
      pass_q    <= hit;
      oor_out_q <= alive_q && oor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_wr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last = &clr_cnt_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign pass_o         = pass_q;
  assign out_of_range_o = oor_out_q;

endmodule
